// File: rtl/mjfd_pkg.sv
// ----------------------------------------------------------------------------
// mjfd_pkg
// Shared types and constants for the MJPEG frame delimiter.
// ----------------------------------------------------------------------------
package mjfd_pkg;

  localparam int MAX_FRAME_BYTES = 65536;
  localparam int MIN_FRAME_BYTES = 2;

  localparam int BYTE_W = 8;
  localparam int CNT_W  = 17;
  localparam int OFF_W  = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [BYTE_W-1:0] SOI_MARK    = 8'hD8;
  localparam logic [BYTE_W-1:0] EOI_MARK    = 8'hD9;
  localparam logic [BYTE_W-1:0] PREFIX_MARK = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MJPEG_MODE  = 1'b0,
    CFG_FRAME_BYTES = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              store_buffer;
    logic [OFF_W-1:0]  store_offset;
    logic [BYTE_W-1:0] store_byte;
    logic              frame_done;
    logic [CNT_W-1:0]  done_length;
    logic              header_reject;
    logic              overflow_restart;
    logic              frame_ready;
    logic              ready_buffer;
  } res_t;

endpackage

// File: rtl/mjpeg_frame_delimiter_pingpong.sv
// ----------------------------------------------------------------------------
// mjpeg_frame_delimiter_pingpong
// Delimits a byte stream into frames held in two alternating buffers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data_byte) takes one stream byte
//   per transfer. For each byte one result leaves on the out_ channel: the
//   buffer and offset where the byte is stored, the byte itself, and frame
//   status (completion with length, start marker reject, count restart,
//   latest ready buffer).
//   Results are registered. Throughput is one byte per cycle while in_stall is
//   low; the frame state (count, previous byte, buffer selects) updates in the
//   transfer cycle. The output register is backed by a skid register, so a
//   byte is still taken in the cycle the receiver first stalls; in_stall
//   rises only when the skid register is full and falls once the receiver
//   takes a result.
//   Synchronous reset (rst_n low) empties both result registers, selects
//   buffer zero, clears the count, previous byte and ready flag, and sets
//   MJPEG mode with a 65536 byte frame size. The user writes configuration
//   (cfg_we, cfg_index, cfg_wdata) only while idle; it is not enforced.
// ----------------------------------------------------------------------------
module mjpeg_frame_delimiter_pingpong (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mjfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mjfd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mjfd_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_store_buffer,
  output logic [mjfd_pkg::OFF_W-1:0]      out_store_offset,
  output logic [mjfd_pkg::BYTE_W-1:0]     out_store_byte,
  output logic                           out_frame_done,
  output logic [mjfd_pkg::CNT_W-1:0]      out_done_length,
  output logic                           out_header_reject,
  output logic                           out_overflow_restart,
  output logic                           out_frame_ready,
  output logic                           out_ready_buffer
);
  import mjfd_pkg::*;

  localparam logic [CNT_W-1:0] SIZE_RST = CNT_W'(1 << OFF_W);
  localparam logic [CNT_W-1:0] SIZE_MAX =
    (MAX_FRAME_BYTES < (1 << OFF_W)) ? CNT_W'(MAX_FRAME_BYTES) : SIZE_RST;
  localparam logic [CNT_W-1:0] SIZE_MIN = CNT_W'(MIN_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

  logic             mjpeg_mode_r;
  logic [CNT_W-1:0] frame_bytes_r;
  logic             fill_select_r, fill_select_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] previous_byte_r;
  logic             ready_flag_r, ready_flag_nxt;
  logic             ready_select_r, ready_select_nxt;

  res_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;

  logic             accept_in, out_take;
  logic [CNT_W-1:0] size, cnt0, cnt1, cnt_mid;
  logic             done, reject, ovf;
  logic [CNT_W-1:0] done_len;

  assign accept_in = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;

  always_comb begin
    if (frame_bytes_r < SIZE_MIN) begin
      size = SIZE_MIN;
    end else if (frame_bytes_r > SIZE_MAX) begin
      size = SIZE_MAX;
    end else begin
      size = frame_bytes_r;
    end
  end

  always_comb begin
    cnt0     = (byte_count_r >= size) ? '0 : byte_count_r;
    cnt1     = cnt0 + CNT_ONE;
    cnt_mid  = cnt1;
    done     = 1'b0;
    reject   = 1'b0;
    ovf      = 1'b0;
    done_len = '0;
    if (mjpeg_mode_r) begin
      if (cnt1 == CNT_TWO) begin
        if (in_data_byte != SOI_MARK || previous_byte_r != PREFIX_MARK) begin
          cnt_mid = '0;
          reject  = 1'b1;
        end
      end else if (previous_byte_r == PREFIX_MARK && in_data_byte == EOI_MARK) begin
        done     = 1'b1;
        done_len = cnt1;
      end
      if (!done && cnt_mid >= size - CNT_ONE) begin
        ovf = 1'b1;
      end
    end else if (cnt1 == size) begin
      done     = 1'b1;
      done_len = size;
    end

    byte_count_nxt   = (done || ovf) ? '0 : cnt_mid;
    fill_select_nxt  = done ? ~fill_select_r : fill_select_r;
    ready_select_nxt = done ? fill_select_r : ready_select_r;
    ready_flag_nxt   = done | ready_flag_r;

    res.store_buffer     = fill_select_r;
    res.store_offset     = cnt0[OFF_W-1:0];
    res.store_byte       = in_data_byte;
    res.frame_done       = done;
    res.done_length      = done_len;
    res.header_reject    = reject;
    res.overflow_restart = ovf;
    res.frame_ready      = ready_flag_nxt;
    res.ready_buffer     = ready_select_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mjpeg_mode_r    <= 1'b1;
      frame_bytes_r   <= SIZE_RST;
      fill_select_r   <= 1'b0;
      byte_count_r    <= '0;
      previous_byte_r <= '0;
      ready_flag_r    <= 1'b0;
      ready_select_r  <= 1'b0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MJPEG_MODE:  mjpeg_mode_r  <= cfg_wdata[0];
          CFG_FRAME_BYTES: frame_bytes_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept_in) begin
        fill_select_r   <= fill_select_nxt;
        byte_count_r    <= byte_count_nxt;
        previous_byte_r <= in_data_byte;
        ready_flag_r    <= ready_flag_nxt;
        ready_select_r  <= ready_select_nxt;
      end
      if (skid_valid_r) begin
        if (out_take) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept_in) begin
        if (out_valid_r && !out_take) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (accept_in) begin
      if (out_valid_r && !out_take) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_store_buffer     = out_r.store_buffer;
  assign out_store_offset     = out_r.store_offset;
  assign out_store_byte       = out_r.store_byte;
  assign out_frame_done       = out_r.frame_done;
  assign out_done_length      = out_r.done_length;
  assign out_header_reject    = out_r.header_reject;
  assign out_overflow_restart = out_r.overflow_restart;
  assign out_frame_ready      = out_r.frame_ready;
  assign out_ready_buffer     = out_r.ready_buffer;

`ifndef NO_ASSERTIONS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_done_sets_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.frame_done |-> out_r.frame_ready &&
      (out_r.ready_buffer == out_r.store_buffer))
    else $error("completed frame not reported as ready buffer");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.frame_done && (out_r.header_reject || out_r.overflow_restart)))
    else $error("frame completion together with restart flag");

  a_done_swaps: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in && done |=> byte_count_r == '0 && fill_select_r != $past(fill_select_r))
    else $error("completion did not restart count and swap buffers");
`endif

endmodule
